>>> sv/i2cm_pkg.sv
// Shared types and constants for the I2C master byte engine.
package i2cm_pkg;

    localparam int TICK_W = 16;
    localparam int BYTE_W = 8;
    localparam int BIT_W  = 4;
    localparam int PH_W   = 2;

    localparam logic [BIT_W-1:0]  BIT_ACK      = 4'd8;
    localparam logic [PH_W-1:0]   PH_SAMPLE    = 2'd1;
    localparam logic [PH_W-1:0]   PH_LAST_BYTE = 2'd2;
    localparam logic [PH_W-1:0]   PH_LAST_3    = 2'd2;
    localparam logic [PH_W-1:0]   PH_LAST_4    = 2'd3;
    localparam logic [TICK_W-1:0] PHASE_TICKS_RST = 16'd1;

    typedef enum logic [2:0] {
        OP_IDLE    = 3'd0,
        OP_START   = 3'd1,
        OP_RESTART = 3'd2,
        OP_STOP    = 3'd3,
        OP_WRITE   = 3'd4,
        OP_READ    = 3'd5
    } t_op;

    typedef struct packed {
        logic              scl_out;
        logic              sda_out;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] rx_byte;
        logic              ack_ok;
    } t_result;

endpackage

>>> sv/i2cm_step.sv
// Bus sequencer state and the per-beat next-state and result logic.
module i2cm_step import i2cm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [2:0]        i_cmd,
    input  logic [BYTE_W-1:0] i_tx_byte,
    input  logic              i_last_read,
    input  logic              i_sda_in,
    input  logic [TICK_W-1:0] i_limit,
    output t_result           o_res
);

    t_op               r_op,    n_op;
    logic [PH_W-1:0]   r_phase, n_phase;
    logic [BIT_W-1:0]  r_bit,   n_bit;
    logic [TICK_W-1:0] r_tick,  n_tick;
    logic [BYTE_W-1:0] r_tx,    n_tx;
    logic [BYTE_W-1:0] r_rx,    n_rx;
    logic              r_nak,   n_nak;
    logic              r_scl,   n_scl;
    logic              r_sda,   n_sda;
    logic              r_ack,   n_ack;
    logic              done;
    logic              cmd_ok;
    logic              is_byte;
    logic              bit_v;
    logic [TICK_W-1:0] tick_inc;
    logic [PH_W-1:0]   ph_last;

    assign cmd_ok = (i_cmd == OP_START) || (i_cmd == OP_RESTART) || (i_cmd == OP_STOP) ||
                    (i_cmd == OP_WRITE) || (i_cmd == OP_READ);

    always_comb begin
        n_op    = r_op;
        n_phase = r_phase;
        n_bit   = r_bit;
        n_tick  = r_tick;
        n_tx    = r_tx;
        n_rx    = r_rx;
        n_nak   = r_nak;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_ack   = r_ack;
        done    = 1'b0;
        is_byte = 1'b0;
        bit_v   = 1'b1;
        tick_inc = '0;
        ph_last = PH_LAST_3;

        if (r_op == OP_IDLE && cmd_ok) begin
            n_op    = t_op'(i_cmd);
            n_phase = '0;
            n_bit   = '0;
            n_tick  = '0;
            if (i_cmd == OP_WRITE || i_cmd == OP_READ) begin
                n_tx  = i_tx_byte;
                n_nak = i_last_read;
                n_rx  = '0;
            end
        end

        if (n_op != OP_IDLE) begin
            is_byte = (n_op == OP_WRITE) || (n_op == OP_READ);
            if (n_bit < BIT_ACK) begin
                bit_v = (n_op == OP_WRITE) ? n_tx[BYTE_W-1] : 1'b1;
            end else begin
                bit_v = (n_op == OP_WRITE) ? 1'b1 : n_nak;
            end

            case (n_op)
                OP_START: begin
                    case (n_phase)
                        2'd0:    n_scl = 1'b1;
                        2'd1:    n_sda = 1'b0;
                        default: n_scl = 1'b0;
                    endcase
                end
                OP_RESTART: begin
                    case (n_phase)
                        2'd0:    n_sda = 1'b1;
                        2'd1:    n_scl = 1'b1;
                        2'd2:    n_sda = 1'b0;
                        default: n_scl = 1'b0;
                    endcase
                end
                OP_STOP: begin
                    case (n_phase)
                        2'd0:    n_sda = 1'b0;
                        2'd1:    n_scl = 1'b1;
                        default: n_sda = 1'b1;
                    endcase
                end
                default: begin
                    case (n_phase)
                        2'd0:    n_sda = bit_v;
                        2'd1:    n_scl = 1'b1;
                        default: n_scl = 1'b0;
                    endcase
                end
            endcase

            ph_last  = (n_op == OP_RESTART) ? PH_LAST_4 : PH_LAST_3;
            tick_inc = n_tick + 1'b1;
            if (tick_inc >= i_limit) begin
                n_tick = '0;
                if (is_byte) begin
                    if (n_phase == PH_SAMPLE) begin
                        if (n_bit < BIT_ACK) begin
                            n_rx = {n_rx[BYTE_W-2:0], i_sda_in};
                        end else begin
                            n_ack = (n_op == OP_WRITE) ? ~i_sda_in : 1'b0;
                        end
                    end
                    if (n_phase >= PH_LAST_BYTE) begin
                        n_phase = '0;
                        n_tx    = {n_tx[BYTE_W-2:0], 1'b0};
                        if (n_bit >= BIT_ACK) begin
                            n_bit = '0;
                            n_op  = OP_IDLE;
                            done  = 1'b1;
                        end else begin
                            n_bit = n_bit + 1'b1;
                        end
                    end else begin
                        n_phase = n_phase + 1'b1;
                    end
                end else begin
                    if (n_phase >= ph_last) begin
                        n_phase = '0;
                        n_op    = OP_IDLE;
                        done    = 1'b1;
                    end else begin
                        n_phase = n_phase + 1'b1;
                    end
                end
            end else begin
                n_tick = tick_inc;
            end
        end
    end

    always_comb begin
        o_res.scl_out  = n_scl;
        o_res.sda_out  = n_sda;
        o_res.busy_res = (n_op != OP_IDLE);
        o_res.done_res = done;
        o_res.rx_byte  = n_rx;
        o_res.ack_ok   = n_ack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op    <= OP_IDLE;
            r_phase <= '0;
            r_bit   <= '0;
            r_tick  <= '0;
            r_tx    <= '0;
            r_rx    <= '0;
            r_nak   <= 1'b0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_ack   <= 1'b0;
        end else if (i_take) begin
            r_op    <= n_op;
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_tick  <= n_tick;
            r_tx    <= n_tx;
            r_rx    <= n_rx;
            r_nak   <= n_nak;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_ack   <= n_ack;
        end
    end

`ifndef SYNTHESIS
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_op == OP_IDLE |-> (r_phase == '0 && r_bit == '0 && r_tick == '0))
        else $error("idle with sequencer counters not cleared");
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bit <= BIT_ACK) && ((r_op == OP_START || r_op == OP_RESTART ||
        r_op == OP_STOP) ? (r_bit == '0) : 1'b1))
        else $error("bit counter out of range");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && o_res.done_res |=> r_op == OP_IDLE && !$past(o_res.busy_res))
        else $error("command finished but sequencer not idle");
`endif

endmodule

>>> sv/i2cm_outq.sv
// Two-entry result queue between the sequencer and the output channel.
module i2cm_outq import i2cm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_valid,
    output t_result o_data
);

    t_result    r_q [0:1];
    logic       r_wr, n_wr;
    logic       r_rd, n_rd;
    logic [1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q[r_rd];

    always_comb begin
        n_wr  = i_push ? ~r_wr : r_wr;
        n_rd  = i_pop  ? ~r_rd : r_rd;
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != 2'd2) && !(i_pop && r_cnt == 2'd0))
        else $error("result queue push when full or pop when empty");
`endif

endmodule

>>> sv/i2c_master_byte_engine_core.sv
// Top level of the I2C master byte engine: config register, sequencer, result queue.
// The result of a beat is computed combinationally and registered in the result queue, which presents it on the output.
// Throughput: one input beat per cycle; the two-entry result queue stalls input only when full.
// Reset (synchronous, active low): sequencer idle, SCL and SDA released, phase_ticks = 1,
// result queue empty.
module i2c_master_byte_engine_core import i2cm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [TICK_W-1:0] i_cfg_wr_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [2:0]        i_cmd,
    input  logic [BYTE_W-1:0] i_tx_byte,
    input  logic              i_last_read,
    input  logic              i_sda_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_scl_out,
    output logic              o_sda_out,
    output logic              o_busy_res,
    output logic              o_done_res,
    output logic [BYTE_W-1:0] o_rx_byte,
    output logic              o_ack_ok
);

    logic [TICK_W-1:0] r_phase_ticks;
    logic [TICK_W-1:0] limit;
    logic              take;
    logic              pop;
    logic              full;
    t_result           step_res;
    t_result           out_res;

    assign limit = (r_phase_ticks == '0) ? PHASE_TICKS_RST : r_phase_ticks;
    assign take  = i_in_valid && !full;
    assign pop   = o_out_valid && !i_out_stall;

    assign o_in_stall = full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RST;
        end else if (i_cfg_wr_en) begin
            r_phase_ticks <= i_cfg_wr_data;
        end
    end

    i2cm_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_cmd       (i_cmd),
        .i_tx_byte   (i_tx_byte),
        .i_last_read (i_last_read),
        .i_sda_in    (i_sda_in),
        .i_limit     (limit),
        .o_res       (step_res)
    );

    i2cm_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_data  (step_res),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (o_out_valid),
        .o_data  (out_res)
    );

    assign o_scl_out  = out_res.scl_out;
    assign o_sda_out  = out_res.sda_out;
    assign o_busy_res = out_res.busy_res;
    assign o_done_res = out_res.done_res;
    assign o_rx_byte  = out_res.rx_byte;
    assign o_ack_ok   = out_res.ack_ok;

endmodule
